// ----- hw/rtl/mjts_pkg.sv -----
// Shared types, constants and arithmetic helpers of the minimum-jerk step pipeline.
`timescale 1ns / 1ps

package mjts_pkg;

   // restoring divider: one quotient bit per stage over a 63-bit numerator
   localparam int DIV_BITS   = 63;
   localparam int DIV_STEPS  = DIV_BITS;
   localparam int MUL_LAT    = 5;
   localparam int LEVEL_LAT  = MUL_LAT + 1;
   localparam int NUM_TERMS  = 15;
   localparam int SUM_STEPS  = 5;
   localparam int W_BITS     = 40;
   localparam int Q_FRAC     = 30;
   localparam int NUM_MULS   = 14 + NUM_TERMS;

   localparam logic [31:0] STEP_TIME_RESET = 32'd16777;
   localparam logic [31:0] MIN_REM_RESET   = 32'd16777;

   // register index taken from paddr[2]
   localparam logic CSR_STEP_TIME = 1'b0;
   localparam logic CSR_MIN_REM   = 1'b1;

   // product shift of each multiplier, same order as the operand table in the top level
   localparam int MUL_SHIFT [NUM_MULS] = '{
      30, 30, 24, 24, 24, 24, 30, 30,
      30, 30, 25, 25,
      30,
      30,
      30, 30, 30, 30, 30,
      30, 30, 30, 31, 31,
      30, 30, 30, 31, 31
   };

   typedef enum logic [1:0] {
      STATUS_ADVANCED = 2'd0,
      STATUS_INACTIVE = 2'd1,
      STATUS_REJECTED = 2'd2
   } step_status_type;

   typedef struct packed {
      step_status_type    status;
      logic               last;
      logic signed [31:0] p0;
      logic signed [31:0] v0;
      logic signed [31:0] a0;
      logic signed [31:0] v1;
      logic signed [31:0] a1;
      logic signed [32:0] d;
      logic [31:0]        t;
   } item_type;

   typedef struct packed {
      logic [DIV_BITS-1:0] num;
      logic [31:0]         rem;
   } div_lane_type;

   typedef struct packed {
      item_type     item;
      div_lane_type ls;
      div_lane_type lr;
   } div_stage_type;

   typedef logic [NUM_TERMS-1:0][W_BITS-1:0] weight_vec_type;
   typedef logic [NUM_TERMS-1:0][63:0]       term_vec_type;

   typedef struct packed {
      item_type           item;
      logic [30:0]        s;
      logic [30:0]        s2;
      logic [30:0]        s3;
      logic [30:0]        s4;
      logic [30:0]        s5;
      logic [54:0]        r;
      logic signed [63:0] dr;
      logic signed [63:0] dr2;
      logic signed [63:0] v0t;
      logic signed [63:0] v1t;
      logic signed [63:0] a0t;
      logic signed [63:0] a1t;
      logic signed [63:0] a0t2;
      logic signed [63:0] a1t2;
      logic signed [63:0] v0r;
      logic signed [63:0] v1r;
      weight_vec_type     w;
      term_vec_type       term;
      logic signed [63:0] pos;
      logic signed [63:0] vel;
      logic signed [63:0] acc;
   } work_type;

   // one restoring step: shift in the next numerator bit, subtract when it fits
   function automatic div_lane_type div_step(input div_lane_type x, input logic [31:0] den);
      logic [32:0]  trial;
      div_lane_type y;
      trial = {x.rem, x.num[DIV_BITS-1]};
      y.num = {x.num[DIV_BITS-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
         y.rem    = 32'(trial - {1'b0, den});
         y.num[0] = 1'b1;
      end else begin
         y.rem    = trial[31:0];
      end
      return y;
   endfunction

   // polynomial weights in s, Q30; order: position, velocity, acceleration terms
   function automatic weight_vec_type weights(input logic [30:0] s, input logic [30:0] s2,
                                              input logic [30:0] s3, input logic [30:0] s4,
                                              input logic [30:0] s5);
      logic signed [W_BITS-1:0] e1;
      logic signed [W_BITS-1:0] e2;
      logic signed [W_BITS-1:0] e3;
      logic signed [W_BITS-1:0] e4;
      logic signed [W_BITS-1:0] e5;
      logic signed [W_BITS-1:0] one;
      weight_vec_type           w;
      e1  = W_BITS'(s);
      e2  = W_BITS'(s2);
      e3  = W_BITS'(s3);
      e4  = W_BITS'(s4);
      e5  = W_BITS'(s5);
      one = W_BITS'(64'd1 << Q_FRAC);
      w[0]  = W_BITS'(10 * e3 - 15 * e4 + 6 * e5);
      w[1]  = W_BITS'(e1 - 6 * e3 + 8 * e4 - 3 * e5);
      w[2]  = W_BITS'(-4 * e3 + 7 * e4 - 3 * e5);
      w[3]  = W_BITS'(e2 - 3 * e3 + 3 * e4 - e5);
      w[4]  = W_BITS'(e3 - 2 * e4 + e5);
      w[5]  = W_BITS'(30 * e2 - 60 * e3 + 30 * e4);
      w[6]  = W_BITS'(one - 18 * e2 + 32 * e3 - 15 * e4);
      w[7]  = W_BITS'(-12 * e2 + 28 * e3 - 15 * e4);
      w[8]  = W_BITS'(2 * e1 - 9 * e2 + 12 * e3 - 5 * e4);
      w[9]  = W_BITS'(3 * e2 - 8 * e3 + 5 * e4);
      w[10] = W_BITS'(60 * e1 - 180 * e2 + 120 * e3);
      w[11] = W_BITS'(-36 * e1 + 96 * e2 - 60 * e3);
      w[12] = W_BITS'(-24 * e1 + 84 * e2 - 60 * e3);
      w[13] = W_BITS'(2 * one - 18 * e1 + 36 * e2 - 20 * e3);
      w[14] = W_BITS'(6 * e1 - 24 * e2 + 20 * e3);
      return w;
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] sum;
      sum = 65'(a) + 65'(b);
      if (sum[64] != sum[63]) begin
         return sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return sum[63:0];
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'h7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

// ----- hw/rtl/mjts_mulq.sv -----
// Pipelined signed multiply with round-half-away shift and 64-bit saturation.
`timescale 1ns / 1ps

module mjts_mulq
   import mjts_pkg::*;
#(
   parameter int SHIFT = Q_FRAC
) (
   input  logic               clock,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic signed [63:0] y
);

   logic [63:0]  ua_ff;
   logic [63:0]  ub_ff;
   logic         neg1_ff;
   logic [63:0]  ll_ff;
   logic [63:0]  lh_ff;
   logic [63:0]  hl_ff;
   logic [63:0]  hh_ff;
   logic         neg2_ff;
   logic [127:0] prod_ff;
   logic         neg3_ff;
   logic [62:0]  mag_ff;
   logic         neg4_ff;
   logic signed [63:0] y_ff;

   logic [128:0] rounded;
   logic [128:0] shifted;
   logic [62:0]  mag_in;

   // round at the shift, then clamp the magnitude
   always_comb begin
      rounded = {1'b0, prod_ff} + (129'd1 << (SHIFT - 1));
      shifted = rounded >> SHIFT;
      if (shifted[128:63] != '0) begin
         mag_in = {63{1'b1}};
      end else begin
         mag_in = shifted[62:0];
      end
   end

   always_ff @(posedge clock) begin
      ua_ff   <= a[63] ? 64'(-a) : 64'(a);
      ub_ff   <= b[63] ? 64'(-b) : 64'(b);
      neg1_ff <= a[63] != b[63];
      ll_ff   <= 64'(ua_ff[31:0])  * 64'(ub_ff[31:0]);
      lh_ff   <= 64'(ua_ff[31:0])  * 64'(ub_ff[63:32]);
      hl_ff   <= 64'(ua_ff[63:32]) * 64'(ub_ff[31:0]);
      hh_ff   <= 64'(ua_ff[63:32]) * 64'(ub_ff[63:32]);
      neg2_ff <= neg1_ff;
      prod_ff <= 128'(ll_ff) + (128'(lh_ff) << 32) + (128'(hl_ff) << 32)
                 + (128'(hh_ff) << 64);
      neg3_ff <= neg2_ff;
      mag_ff  <= mag_in;
      neg4_ff <= neg3_ff;
      y_ff    <= neg4_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
   end

   assign y = y_ff;

endmodule

// ----- hw/rtl/min_jerk_trajectory_step.sv -----
// Top level of the minimum-jerk quintic trajectory step pipeline.
`timescale 1ns / 1ps

// One axis of a quintic minimum-jerk path per transaction. Raise start with the
// req_ fields; the transaction is taken at any edge where start is high and busy
// is low. busy stays low: the pipeline takes a new axis every cycle.
// Each axis gives exactly one result: rsp_valid is high for one cycle with the
// rsp_ fields, registered after the last sum stage, in acceptance order.
// The latency is set by the 63-stage restoring divider that forms s = h/T and
// 1/T (one quotient bit per stage), four chained multiply levels for the powers
// of s, one level of term products and a five-stage saturating sum.
// Each multiply level runs through a unit built from 32x32 partial products and
// then through the work register that catches its result.
// The receiver cannot stall, so nothing is held back and nothing is dropped.
// Reset clears the valid bits of every stage and loads step_time and
// min_remaining_time with one servo period (16777 in Q8.24).
// Write the two registers through the APB port (byte 0 and 4) only while no
// transaction is in flight.
module min_jerk_trajectory_step
   import mjts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_axis_active,
   input  logic signed [31:0] req_cur_pos,
   input  logic signed [31:0] req_cur_vel,
   input  logic signed [31:0] req_cur_acc,
   input  logic signed [31:0] req_goal_pos,
   input  logic signed [31:0] req_goal_vel,
   input  logic signed [31:0] req_goal_acc,
   input  logic [31:0]        req_remaining_time,
   input  logic               req_last_axis,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_next_pos,
   output logic signed [31:0] rsp_next_vel,
   output logic signed [31:0] rsp_next_acc,
   output logic [1:0]         rsp_step_status,
   output logic               rsp_last_axis_out,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // pipeline positions
   localparam int P_DIV  = DIV_STEPS;
   localparam int P_WORK = P_DIV + 1;
   localparam int P_L1   = P_DIV + LEVEL_LAT;
   localparam int P_L2   = P_L1 + LEVEL_LAT;
   localparam int P_L3   = P_L2 + LEVEL_LAT;
   localparam int P_L4   = P_L3 + LEVEL_LAT;
   localparam int P_W    = P_L4 + 1;
   localparam int P_T    = P_W + LEVEL_LAT;
   localparam int P_LAST = P_T + SUM_STEPS;
   localparam int RSP_LAT = P_LAST + 2;

   // multiplier slots
   localparam int M_S2    = 0;
   localparam int M_DR    = 1;
   localparam int M_V0T   = 2;
   localparam int M_V1T   = 3;
   localparam int M_A0T   = 4;
   localparam int M_A1T   = 5;
   localparam int M_V0R   = 6;
   localparam int M_V1R   = 7;
   localparam int M_S3    = 8;
   localparam int M_DR2   = 9;
   localparam int M_A0T2  = 10;
   localparam int M_A1T2  = 11;
   localparam int M_S4    = 12;
   localparam int M_S5    = 13;
   localparam int M_TERM  = 14;

   logic [31:0] step_time_ff;
   logic [31:0] min_rem_ff;
   logic        csr_write;

   logic          take;
   div_stage_type div_in [0:P_DIV];
   div_stage_type div_ff [0:P_DIV];
   work_type      work_in [P_WORK:P_LAST];
   work_type      work_ff [P_WORK:P_LAST];
   logic [P_LAST:0] vld_ff;

   logic signed [63:0] mul_a [NUM_MULS];
   logic signed [63:0] mul_b [NUM_MULS];
   logic signed [63:0] mul_y [NUM_MULS];

   logic [30:0] div_s;
   logic [54:0] div_r;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_pos_ff;
   logic signed [31:0] rsp_vel_ff;
   logic signed [31:0] rsp_acc_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_last_ff;

   // ---------------------------------------------------------------------
   // Configuration port: zero wait states, index from paddr[2]
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= STEP_TIME_RESET;
         min_rem_ff   <= MIN_REM_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            CSR_STEP_TIME: step_time_ff <= pwdata;
            CSR_MIN_REM:   min_rem_ff   <= pwdata;
            default:       ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_STEP_TIME: prdata = step_time_ff;
         CSR_MIN_REM:   prdata = min_rem_ff;
         default:       prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Capture and divider: the status is settled at entry, both quotients
   // (h*2^30/T and 2^54/T, rounded by adding T/2) advance one bit a stage
   // ---------------------------------------------------------------------
   assign busy = 1'b0;
   assign take = start & ~busy;

   always_comb begin
      div_in[0].item.last = req_last_axis;
      div_in[0].item.p0   = req_cur_pos;
      div_in[0].item.v0   = req_cur_vel;
      div_in[0].item.a0   = req_cur_acc;
      div_in[0].item.v1   = req_goal_vel;
      div_in[0].item.a1   = req_goal_acc;
      div_in[0].item.d    = 33'(req_goal_pos) - 33'(req_cur_pos);
      div_in[0].item.t    = req_remaining_time;
      if (step_time_ff == '0 || step_time_ff > req_remaining_time
          || req_remaining_time < min_rem_ff) begin
         div_in[0].item.status = STATUS_REJECTED;
      end else if (!req_axis_active) begin
         div_in[0].item.status = STATUS_INACTIVE;
      end else begin
         div_in[0].item.status = STATUS_ADVANCED;
      end
      div_in[0].ls.num = (DIV_BITS'(step_time_ff) << Q_FRAC)
                         + DIV_BITS'(req_remaining_time >> 1);
      div_in[0].ls.rem = '0;
      div_in[0].lr.num = (DIV_BITS'(1) << (2 * Q_FRAC - 6))
                         + DIV_BITS'(req_remaining_time >> 1);
      div_in[0].lr.rem = '0;
      for (int k = 1; k <= P_DIV; k++) begin
         div_in[k].item = div_ff[k-1].item;
         div_in[k].ls   = div_step(div_ff[k-1].ls, div_ff[k-1].item.t);
         div_in[k].lr   = div_step(div_ff[k-1].lr, div_ff[k-1].item.t);
      end
   end

   assign div_s = div_ff[P_DIV].ls.num[30:0];
   assign div_r = div_ff[P_DIV].lr.num[54:0];

   // ---------------------------------------------------------------------
   // Multiplier operands: each level reads the stage where its inputs sit
   // ---------------------------------------------------------------------
   always_comb begin
      mul_a[M_S2]   = 64'(div_s);
      mul_b[M_S2]   = 64'(div_s);
      mul_a[M_DR]   = 64'(div_ff[P_DIV].item.d);
      mul_b[M_DR]   = 64'(div_r);
      mul_a[M_V0T]  = 64'(div_ff[P_DIV].item.v0);
      mul_b[M_V0T]  = 64'(div_ff[P_DIV].item.t);
      mul_a[M_V1T]  = 64'(div_ff[P_DIV].item.v1);
      mul_b[M_V1T]  = 64'(div_ff[P_DIV].item.t);
      mul_a[M_A0T]  = 64'(div_ff[P_DIV].item.a0);
      mul_b[M_A0T]  = 64'(div_ff[P_DIV].item.t);
      mul_a[M_A1T]  = 64'(div_ff[P_DIV].item.a1);
      mul_b[M_A1T]  = 64'(div_ff[P_DIV].item.t);
      mul_a[M_V0R]  = 64'(div_ff[P_DIV].item.v0);
      mul_b[M_V0R]  = 64'(div_r);
      mul_a[M_V1R]  = 64'(div_ff[P_DIV].item.v1);
      mul_b[M_V1R]  = 64'(div_r);

      mul_a[M_S3]   = 64'(work_ff[P_L1].s2);
      mul_b[M_S3]   = 64'(work_ff[P_L1].s);
      mul_a[M_DR2]  = work_ff[P_L1].dr;
      mul_b[M_DR2]  = 64'(work_ff[P_L1].r);
      mul_a[M_A0T2] = work_ff[P_L1].a0t;
      mul_b[M_A0T2] = 64'(work_ff[P_L1].item.t);
      mul_a[M_A1T2] = work_ff[P_L1].a1t;
      mul_b[M_A1T2] = 64'(work_ff[P_L1].item.t);

      mul_a[M_S4]   = 64'(work_ff[P_L2].s3);
      mul_b[M_S4]   = 64'(work_ff[P_L2].s);
      mul_a[M_S5]   = 64'(work_ff[P_L3].s4);
      mul_b[M_S5]   = 64'(work_ff[P_L3].s);

      // position terms
      mul_a[M_TERM + 0]  = 64'(work_ff[P_W].item.d);
      mul_a[M_TERM + 1]  = work_ff[P_W].v0t;
      mul_a[M_TERM + 2]  = work_ff[P_W].v1t;
      mul_a[M_TERM + 3]  = work_ff[P_W].a0t2;
      mul_a[M_TERM + 4]  = work_ff[P_W].a1t2;
      // velocity terms
      mul_a[M_TERM + 5]  = work_ff[P_W].dr;
      mul_a[M_TERM + 6]  = 64'(work_ff[P_W].item.v0);
      mul_a[M_TERM + 7]  = 64'(work_ff[P_W].item.v1);
      mul_a[M_TERM + 8]  = work_ff[P_W].a0t;
      mul_a[M_TERM + 9]  = work_ff[P_W].a1t;
      // acceleration terms
      mul_a[M_TERM + 10] = work_ff[P_W].dr2;
      mul_a[M_TERM + 11] = work_ff[P_W].v0r;
      mul_a[M_TERM + 12] = work_ff[P_W].v1r;
      mul_a[M_TERM + 13] = 64'(work_ff[P_W].item.a0);
      mul_a[M_TERM + 14] = 64'(work_ff[P_W].item.a1);
      for (int i = 0; i < NUM_TERMS; i++) begin
         mul_b[M_TERM + i] = 64'($signed(work_ff[P_W].w[i]));
      end
   end

   for (genvar g = 0; g < NUM_MULS; g++) begin : g_mul
      mjts_mulq #(
         .SHIFT (MUL_SHIFT[g])
      ) u_mulq (
         .clock (clock),
         .a     (mul_a[g]),
         .b     (mul_b[g]),
         .y     (mul_y[g])
      );
   end

   // ---------------------------------------------------------------------
   // Work stages: advance every stage, drop each product in where it lands
   // ---------------------------------------------------------------------
   always_comb begin
      work_in[P_WORK]      = '0;
      work_in[P_WORK].item = div_ff[P_DIV].item;
      work_in[P_WORK].s    = div_s;
      work_in[P_WORK].r    = div_r;
      for (int k = P_WORK + 1; k <= P_LAST; k++) begin
         work_in[k] = work_ff[k-1];
      end

      work_in[P_L1].s2  = mul_y[M_S2][30:0];
      work_in[P_L1].dr  = mul_y[M_DR];
      work_in[P_L1].v0t = mul_y[M_V0T];
      work_in[P_L1].v1t = mul_y[M_V1T];
      work_in[P_L1].a0t = mul_y[M_A0T];
      work_in[P_L1].a1t = mul_y[M_A1T];
      work_in[P_L1].v0r = mul_y[M_V0R];
      work_in[P_L1].v1r = mul_y[M_V1R];

      work_in[P_L2].s3   = mul_y[M_S3][30:0];
      work_in[P_L2].dr2  = mul_y[M_DR2];
      work_in[P_L2].a0t2 = mul_y[M_A0T2];
      work_in[P_L2].a1t2 = mul_y[M_A1T2];

      work_in[P_L3].s4 = mul_y[M_S4][30:0];
      work_in[P_L4].s5 = mul_y[M_S5][30:0];

      work_in[P_W].w = weights(work_ff[P_W-1].s, work_ff[P_W-1].s2, work_ff[P_W-1].s3,
                               work_ff[P_W-1].s4, work_ff[P_W-1].s5);

      for (int i = 0; i < NUM_TERMS; i++) begin
         work_in[P_T].term[i] = mul_y[M_TERM + i];
      end
      work_in[P_T].pos = 64'(work_ff[P_T-1].item.p0);
      work_in[P_T].vel = '0;
      work_in[P_T].acc = '0;

      // add the terms in order, one saturating add per sum and stage
      for (int j = 1; j <= SUM_STEPS; j++) begin
         work_in[P_T+j].pos = sat_add(work_ff[P_T+j-1].pos,
                                      $signed(work_ff[P_T+j-1].term[j-1]));
         work_in[P_T+j].vel = sat_add(work_ff[P_T+j-1].vel,
                                      $signed(work_ff[P_T+j-1].term[SUM_STEPS+j-1]));
         work_in[P_T+j].acc = sat_add(work_ff[P_T+j-1].acc,
                                      $signed(work_ff[P_T+j-1].term[2*SUM_STEPS+j-1]));
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      work_ff <= work_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[P_LAST-1:0], take};
      end
   end

   // ---------------------------------------------------------------------
   // Result register: saturate to Q16.16, or pass the current state through
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[P_LAST];
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= work_ff[P_LAST].item.status;
      rsp_last_ff   <= work_ff[P_LAST].item.last;
      if (work_ff[P_LAST].item.status == STATUS_ADVANCED) begin
         rsp_pos_ff <= sat32(work_ff[P_LAST].pos);
         rsp_vel_ff <= sat32(work_ff[P_LAST].vel);
         rsp_acc_ff <= sat32(work_ff[P_LAST].acc);
      end else begin
         rsp_pos_ff <= work_ff[P_LAST].item.p0;
         rsp_vel_ff <= work_ff[P_LAST].item.v0;
         rsp_acc_ff <= work_ff[P_LAST].item.a0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_pos      = rsp_pos_ff;
   assign rsp_next_vel      = rsp_vel_ff;
   assign rsp_next_acc      = rsp_acc_ff;
   assign rsp_step_status   = rsp_status_ff;
   assign rsp_last_axis_out = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // every accepted transaction comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      take |-> ##RSP_LAT rsp_valid)
      else $error("result missing after fixed latency");

   // the marker travels with its own transaction
   a_marker: assert property (@(posedge clock) disable iff (reset)
      take |-> ##RSP_LAT (rsp_last_axis_out == $past(req_last_axis, RSP_LAT)))
      else $error("last-axis marker out of step");

   // an inactive axis returns its current state untouched; position and acceleration are checked
   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_step_status == STATUS_INACTIVE)
      |-> (rsp_next_pos == $past(req_cur_pos, RSP_LAT)
           && rsp_next_acc == $past(req_cur_acc, RSP_LAT)))
      else $error("inactive axis not passed through");
`endif

endmodule
